FILE: rtl/nfdt_pkg.sv
// Shared constants for the normal frame direction transform.
// No dependencies; every other file in the block refers to this package.
`timescale 1ns / 1ps

package nfdt_pkg;

    // Default signed width of every vector component.
    localparam int COMPONENT_WIDTH = 18;
    // Fraction bits of the fixed-point format.
    localparam int FRAC_BITS = 16;

    // Helper-axis threshold register.
    localparam int THR_W = 17;
    localparam logic [THR_W-1:0] THR_RESET = 17'd65470;

    // A vector is shifted until its largest magnitude lies below 2^D_LIMIT.
    localparam int D_LIMIT = 20;
    // Shifted component, signed; holds -2^20 .. 2^20-1.
    localparam int D_W = D_LIMIT + 1;
    // Square of a shifted component and the sum of three squares.
    localparam int SQ_W = 2 * D_LIMIT + 1;
    localparam int SUM_W = 2 * D_LIMIT + 2;
    // Radicand of the length root and the root itself.
    localparam int RAD_W = SUM_W + FRAC_BITS;
    localparam int LEN_W = RAD_W / 2;
    // Scale of the numerator of each unit component.
    localparam int UNIT_SHIFT = 24;
    // Magnitude and signed width of a unit component.
    localparam int Q_W = 18;
    localparam int U_W = Q_W + 1;

endpackage

FILE: rtl/nfdt_in_if.sv
// Input channel of the normal frame direction transform: handshake and payload.
// Depends on nfdt_pkg for the default component width.
`timescale 1ns / 1ps

interface nfdt_in_if #(
    parameter int W = nfdt_pkg::COMPONENT_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] local_x;
    logic signed [W-1:0] local_y;
    logic signed [W-1:0] local_z;
    logic signed [W-1:0] normal_x;
    logic signed [W-1:0] normal_y;
    logic signed [W-1:0] normal_z;

    modport source (
        output valid, local_x, local_y, local_z, normal_x, normal_y, normal_z,
        input  ready
    );

    modport sink (
        input  valid, local_x, local_y, local_z, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

FILE: rtl/nfdt_out_if.sv
// Output channel of the normal frame direction transform: handshake and payload.
// Depends on nfdt_pkg for the default component width.
`timescale 1ns / 1ps

interface nfdt_out_if #(
    parameter int W = nfdt_pkg::COMPONENT_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] world_x;
    logic signed [W-1:0] world_y;
    logic signed [W-1:0] world_z;
    logic                degenerate;

    modport source (
        output valid, world_x, world_y, world_z, degenerate,
        input  ready
    );

    modport sink (
        input  valid, world_x, world_y, world_z, degenerate,
        output ready
    );
endinterface

FILE: rtl/nfdt_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on nfdt_pkg for the radicand and root widths.
`timescale 1ns / 1ps

module nfdt_sqrt #(
    parameter int SB_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [nfdt_pkg::RAD_W-1:0]    radicand,
    input  logic [SB_W-1:0]               sb_in,
    output logic                          out_vld,
    output logic [nfdt_pkg::LEN_W-1:0]    root,
    output logic [SB_W-1:0]               sb_out
);
    localparam int N  = nfdt_pkg::LEN_W;
    localparam int XW = nfdt_pkg::RAD_W;
    localparam int RW = N + 3;

    logic [XW-1:0]   x_s    [0:N];
    logic [RW-1:0]   rem_s  [0:N];
    logic [N-1:0]    root_s [0:N];
    logic            vld_s  [0:N];
    logic [SB_W-1:0] sb_s   [0:N];

    assign x_s[0]    = radicand;
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;
    assign vld_s[0]  = in_vld;
    assign sb_s[0]   = sb_in;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_step
            logic [RW-1:0]   rem_t;
            logic [RW-1:0]   trial;
            logic [RW-1:0]   rem_next;
            logic [N-1:0]    root_next;
            logic [XW-1:0]   x_reg;
            logic [RW-1:0]   rem_reg;
            logic [N-1:0]    root_reg;
            logic            vld_reg;
            logic [SB_W-1:0] sb_reg;

            // Bring down the next two radicand bits and try the next root bit.
            always_comb
            begin
                rem_t = {rem_s[i][RW-3:0], x_s[i][XW-1-2*i -: 2]};
                trial = RW'({root_s[i], 2'b01});
                if (rem_t >= trial)
                begin
                    rem_next  = rem_t - trial;
                    root_next = {root_s[i][N-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t;
                    root_next = {root_s[i][N-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg <= vld_s[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg    <= x_s[i];
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    sb_reg   <= sb_s[i];
                end
            end

            assign x_s[i+1]    = x_reg;
            assign rem_s[i+1]  = rem_reg;
            assign root_s[i+1] = root_reg;
            assign vld_s[i+1]  = vld_reg;
            assign sb_s[i+1]   = sb_reg;
        end
    endgenerate

    assign out_vld = vld_s[N];
    assign root    = root_s[N];
    assign sb_out  = sb_s[N];

endmodule

FILE: rtl/nfdt_div.sv
// Pipelined three-lane restoring divider: each component divided by the length.
// Depends on nfdt_pkg for the component, length and quotient widths.
`timescale 1ns / 1ps

module nfdt_div #(
    parameter int SB_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_vld,
    input  logic signed [nfdt_pkg::D_W-1:0]     num [3],
    input  logic [nfdt_pkg::LEN_W-1:0]          den,
    input  logic [SB_W-1:0]                     sb_in,
    output logic                                out_vld,
    output logic signed [nfdt_pkg::U_W-1:0]     quot [3],
    output logic [SB_W-1:0]                     sb_out
);
    localparam int N     = nfdt_pkg::Q_W;
    localparam int DW    = nfdt_pkg::D_W;
    localparam int LW    = nfdt_pkg::LEN_W;
    localparam int REM_W = DW + nfdt_pkg::UNIT_SHIFT + 1;
    localparam int CMP_W = ((REM_W > LW + N) ? REM_W : LW + N) + 1;

    logic [REM_W-1:0] rem_s [0:N][3];
    logic [N-1:0]     q_s   [0:N][3];
    logic             neg_s [0:N][3];
    logic [LW-1:0]    den_s [0:N];
    logic             vld_s [0:N];
    logic [SB_W-1:0]  sb_s  [0:N];

    // Numerator is the magnitude scaled up, plus half the length for rounding.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            logic [DW-1:0] m;
            m = num[l][DW-1] ? DW'(-num[l]) : DW'(num[l]);
            rem_s[0][l] = REM_W'({m, {nfdt_pkg::UNIT_SHIFT{1'b0}}}) + REM_W'(den >> 1);
            q_s[0][l]   = '0;
            neg_s[0][l] = num[l][DW-1];
        end
    end

    assign den_s[0] = den;
    assign vld_s[0] = in_vld;
    assign sb_s[0]  = sb_in;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_step
            localparam int J = N - 1 - i;
            logic [CMP_W-1:0] trial;
            logic [REM_W-1:0] rem_next [3];
            logic [N-1:0]     q_next   [3];
            logic [REM_W-1:0] rem_reg  [3];
            logic [N-1:0]     q_reg    [3];
            logic             neg_reg  [3];
            logic [LW-1:0]    den_reg;
            logic             vld_reg;
            logic [SB_W-1:0]  sb_reg;

            // One quotient bit per lane against the shifted length.
            always_comb
            begin
                trial = CMP_W'(den_s[i]) << J;
                for (int l = 0; l < 3; l++)
                begin
                    rem_next[l] = rem_s[i][l];
                    q_next[l]   = q_s[i][l];
                    if (CMP_W'(rem_s[i][l]) >= trial)
                    begin
                        rem_next[l] = REM_W'(CMP_W'(rem_s[i][l]) - trial);
                        q_next[l][J] = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg <= vld_s[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                    neg_reg <= neg_s[i];
                    den_reg <= den_s[i];
                    sb_reg  <= sb_s[i];
                end
            end

            assign rem_s[i+1] = rem_reg;
            assign q_s[i+1]   = q_reg;
            assign neg_s[i+1] = neg_reg;
            assign den_s[i+1] = den_reg;
            assign vld_s[i+1] = vld_reg;
            assign sb_s[i+1]  = sb_reg;
        end
    endgenerate

    // Restore the sign of each lane.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            quot[l] = neg_s[N][l] ? -$signed(nfdt_pkg::U_W'(q_s[N][l]))
                                  :  $signed(nfdt_pkg::U_W'(q_s[N][l]));
        end
    end

    assign out_vld = vld_s[N];
    assign sb_out  = sb_s[N];

endmodule

FILE: rtl/nfdt_norm.sv
// Vector normaliser: range reduction, sum of squares, length root and division.
// Depends on nfdt_pkg, nfdt_sqrt and nfdt_div.
`timescale 1ns / 1ps

module nfdt_norm #(
    parameter int CW   = nfdt_pkg::COMPONENT_WIDTH + 1,
    parameter int SB_W = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic signed [CW-1:0]              c [3],
    input  logic [SB_W-1:0]                   sb_in,
    output logic                              out_vld,
    output logic signed [nfdt_pkg::U_W-1:0]   o [3],
    output logic                              zero,
    output logic [SB_W-1:0]                   sb_out
);
    localparam int DW  = nfdt_pkg::D_W;
    localparam int KW  = (CW > 1) ? $clog2(CW) : 1;
    localparam int XW  = (CW > DW) ? CW : DW;
    localparam int SQB = 3 * DW + 1 + SB_W;
    localparam int DVB = 1 + SB_W;

    // Stage A: magnitudes merged into one mask of occupied bits.
    logic signed [CW-1:0] ca_reg [3];
    logic [CW-1:0]        orr_reg;
    logic                 vld_a_reg;
    logic [SB_W-1:0]      sb_a_reg;
    logic [CW-1:0]        orr_next;

    always_comb
    begin
        orr_next = '0;
        for (int l = 0; l < 3; l++)
        begin
            orr_next = orr_next | (c[l][CW-1] ? CW'(-c[l]) : CW'(c[l]));
        end
    end

    // Stage B: shift that brings the largest magnitude below the limit.
    logic signed [CW-1:0] cb_reg [3];
    logic [KW-1:0]        k_reg;
    logic                 vld_b_reg;
    logic [SB_W-1:0]      sb_b_reg;
    logic [KW-1:0]        k_next;

    always_comb
    begin
        k_next = '0;
        for (int b = nfdt_pkg::D_LIMIT; b < CW; b++)
        begin
            if (orr_reg[b])
            begin
                k_next = KW'(b - nfdt_pkg::D_LIMIT + 1);
            end
        end
    end

    // Stage C: arithmetic shift, which rounds towards minus infinity.
    logic signed [DW-1:0] d_reg [3];
    logic                 vld_c_reg;
    logic [SB_W-1:0]      sb_c_reg;
    logic signed [DW-1:0] d_next [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            d_next[l] = DW'(XW'(cb_reg[l]) >>> k_reg);
        end
    end

    // Stage D: squares.
    logic signed [DW-1:0]           dd_reg [3];
    logic [nfdt_pkg::SQ_W-1:0]      sq_reg [3];
    logic                           vld_d_reg;
    logic [SB_W-1:0]                sb_d_reg;

    // Stage E: sum of squares and zero-length test.
    logic signed [DW-1:0]           de_reg [3];
    logic [nfdt_pkg::SUM_W-1:0]     sum_reg;
    logic                           zero_reg;
    logic                           vld_e_reg;
    logic [SB_W-1:0]                sb_e_reg;
    logic [nfdt_pkg::SUM_W-1:0]     sum_next;

    assign sum_next = nfdt_pkg::SUM_W'(sq_reg[0]) + nfdt_pkg::SUM_W'(sq_reg[1])
                    + nfdt_pkg::SUM_W'(sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
            vld_e_reg <= vld_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg   <= c;
            orr_reg  <= orr_next;
            sb_a_reg <= sb_in;
            cb_reg   <= ca_reg;
            k_reg    <= k_next;
            sb_b_reg <= sb_a_reg;
            d_reg    <= d_next;
            sb_c_reg <= sb_b_reg;
            dd_reg   <= d_reg;
            for (int l = 0; l < 3; l++)
            begin
                sq_reg[l] <= nfdt_pkg::SQ_W'(d_reg[l] * d_reg[l]);
            end
            sb_d_reg <= sb_c_reg;
            de_reg   <= dd_reg;
            sum_reg  <= sum_next;
            zero_reg <= (sum_next == '0);
            sb_e_reg <= sb_d_reg;
        end
    end

    // Length root, carrying the shifted components alongside.
    logic                          sq_vld;
    logic [nfdt_pkg::LEN_W-1:0]    len;
    logic [SQB-1:0]                sq_sb;
    logic signed [DW-1:0]          d_len [3];

    nfdt_sqrt #(
        .SB_W (SQB)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_e_reg),
        .radicand ({sum_reg, {nfdt_pkg::FRAC_BITS{1'b0}}}),
        .sb_in    ({de_reg[0], de_reg[1], de_reg[2], zero_reg, sb_e_reg}),
        .out_vld  (sq_vld),
        .root     (len),
        .sb_out   (sq_sb)
    );

    assign d_len[0] = $signed(sq_sb[SQB-1 -: DW]);
    assign d_len[1] = $signed(sq_sb[SQB-1-DW -: DW]);
    assign d_len[2] = $signed(sq_sb[SQB-1-2*DW -: DW]);

    // Component-wise division by the length.
    logic [DVB-1:0] dv_sb;

    nfdt_div #(
        .SB_W (DVB)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (sq_vld),
        .num     (d_len),
        .den     (len),
        .sb_in   (sq_sb[DVB-1:0]),
        .out_vld (out_vld),
        .quot    (o),
        .sb_out  (dv_sb)
    );

    assign zero   = dv_sb[DVB-1];
    assign sb_out = dv_sb[SB_W-1:0];

endmodule

FILE: rtl/normal_frame_direction_transform.sv
// Top level of the normal frame direction transform: tangent frame and rotation.
// Depends on nfdt_pkg, nfdt_in_if, nfdt_out_if and nfdt_norm.
// The pipeline has an input stage, two normalisers (5 range stages, 29 root stages
// and 18 divider stages each), 2 cross stages and 3 output stages.
// Throughput is one transfer per cycle; the whole pipeline holds while a result waits.
// Reset clears every valid bit and loads the axis switch threshold with its default.
`timescale 1ns / 1ps

module normal_frame_direction_transform #(
    parameter int COMPONENT_WIDTH = nfdt_pkg::COMPONENT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [nfdt_pkg::THR_W-1:0]    cfg_wr_data,
    nfdt_in_if.sink                       vec_in,
    nfdt_out_if.source                    vec_out
);
    localparam int W    = COMPONENT_WIDTH;
    localparam int UW   = nfdt_pkg::U_W;
    localparam int CW1  = W + 1;
    localparam int PW   = W + UW;
    localparam int CW2  = PW + 1;
    localparam int AW   = ((PW > 2 * W) ? PW : 2 * W) + 2;
    localparam int RQW  = AW - nfdt_pkg::FRAC_BITS;
    localparam int TW   = (W > nfdt_pkg::THR_W) ? W : nfdt_pkg::THR_W;
    localparam int SB1  = 6 * W;
    localparam int SB2  = 6 * W + 3 * UW + 1;

    // Threshold register.
    logic [nfdt_pkg::THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= nfdt_pkg::THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Global advance: every stage moves unless a finished result is held.
    logic en;
    logic out_vld_reg;

    assign en           = !out_vld_reg || vec_out.ready;
    assign vec_in.ready = en;

    // Stage 0: choose the helper axis and form the first cross product.
    logic signed [W-1:0]   l0_reg [3];
    logic signed [W-1:0]   w0_reg [3];
    logic signed [CW1-1:0] cu_reg [3];
    logic                  vld0_reg;
    logic [W-1:0]          wz_mag;
    logic                  use_x;
    logic signed [CW1-1:0] cu_next [3];

    always_comb
    begin
        wz_mag = vec_in.normal_z[W-1] ? W'(-vec_in.normal_z) : W'(vec_in.normal_z);
        use_x  = TW'(wz_mag) >= TW'(thr_reg);
        if (use_x)
        begin
            cu_next[0] = '0;
            cu_next[1] = -CW1'(vec_in.normal_z);
            cu_next[2] = CW1'(vec_in.normal_y);
        end
        else
        begin
            cu_next[0] = -CW1'(vec_in.normal_y);
            cu_next[1] = CW1'(vec_in.normal_x);
            cu_next[2] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l0_reg[0] <= vec_in.local_x;
            l0_reg[1] <= vec_in.local_y;
            l0_reg[2] <= vec_in.local_z;
            w0_reg[0] <= vec_in.normal_x;
            w0_reg[1] <= vec_in.normal_y;
            w0_reg[2] <= vec_in.normal_z;
            cu_reg    <= cu_next;
        end
    end

    // Tangent.
    logic                 n1_vld;
    logic signed [UW-1:0] u [3];
    logic                 n1_zero;
    logic [SB1-1:0]       n1_sb;

    nfdt_norm #(
        .CW   (CW1),
        .SB_W (SB1)
    ) u_norm_tangent (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld0_reg),
        .c       (cu_reg),
        .sb_in   ({l0_reg[0], l0_reg[1], l0_reg[2], w0_reg[0], w0_reg[1], w0_reg[2]}),
        .out_vld (n1_vld),
        .o       (u),
        .zero    (n1_zero),
        .sb_out  (n1_sb)
    );

    logic signed [W-1:0] l1 [3];
    logic signed [W-1:0] w1 [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            l1[l] = $signed(n1_sb[SB1-1-l*W -: W]);
            w1[l] = $signed(n1_sb[SB1-1-(3+l)*W -: W]);
        end
    end

    // Stage 1: products of the second cross.
    logic signed [PW-1:0] pa_reg [3];
    logic signed [PW-1:0] pb_reg [3];
    logic signed [W-1:0]  l2_reg [3];
    logic signed [W-1:0]  w2_reg [3];
    logic signed [UW-1:0] u2_reg [3];
    logic                 z2_reg;
    logic                 vld1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg[0] <= PW'(w1[1] * u[2]);
            pb_reg[0] <= PW'(w1[2] * u[1]);
            pa_reg[1] <= PW'(w1[2] * u[0]);
            pb_reg[1] <= PW'(w1[0] * u[2]);
            pa_reg[2] <= PW'(w1[0] * u[1]);
            pb_reg[2] <= PW'(w1[1] * u[0]);
            l2_reg    <= l1;
            w2_reg    <= w1;
            u2_reg    <= u;
            z2_reg    <= n1_zero;
        end
    end

    // Stage 2: differences of the second cross.
    logic signed [CW2-1:0] cv_reg [3];
    logic signed [W-1:0]   l3_reg [3];
    logic signed [W-1:0]   w3_reg [3];
    logic signed [UW-1:0]  u3_reg [3];
    logic                  z3_reg;
    logic                  vld2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                cv_reg[l] <= CW2'(pa_reg[l]) - CW2'(pb_reg[l]);
            end
            l3_reg <= l2_reg;
            w3_reg <= w2_reg;
            u3_reg <= u2_reg;
            z3_reg <= z2_reg;
        end
    end

    // Bitangent.
    logic                 n2_vld;
    logic signed [UW-1:0] v [3];
    logic                 n2_zero;
    logic [SB2-1:0]       n2_sb;

    nfdt_norm #(
        .CW   (CW2),
        .SB_W (SB2)
    ) u_norm_bitangent (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld2_reg),
        .c       (cv_reg),
        .sb_in   ({l3_reg[0], l3_reg[1], l3_reg[2], w3_reg[0], w3_reg[1], w3_reg[2],
                   u3_reg[0], u3_reg[1], u3_reg[2], z3_reg}),
        .out_vld (n2_vld),
        .o       (v),
        .zero    (n2_zero),
        .sb_out  (n2_sb)
    );

    logic signed [W-1:0]  l4 [3];
    logic signed [W-1:0]  w4 [3];
    logic signed [UW-1:0] u4 [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            l4[l] = $signed(n2_sb[SB2-1-l*W -: W]);
            w4[l] = $signed(n2_sb[SB2-1-(3+l)*W -: W]);
            u4[l] = $signed(n2_sb[SB2-1-6*W-l*UW -: UW]);
        end
    end

    // Stage 3: products of the frame rotation.
    logic signed [PW-1:0]  mu_reg [3];
    logic signed [PW-1:0]  mv_reg [3];
    logic signed [2*W-1:0] mw_reg [3];
    logic                  deg3_reg;
    logic                  vld3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                mu_reg[l] <= PW'(u4[l] * l4[0]);
                mv_reg[l] <= PW'(v[l] * l4[1]);
                mw_reg[l] <= (2 * W)'(w4[l] * l4[2]);
            end
            deg3_reg <= n2_zero || n2_sb[0];
        end
    end

    // Stage 4: sums.
    logic signed [AW-1:0] acc_reg [3];
    logic                 deg4_reg;
    logic                 vld4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                acc_reg[l] <= AW'(mu_reg[l]) + AW'(mv_reg[l]) + AW'(mw_reg[l]);
            end
            deg4_reg <= deg3_reg;
        end
    end

    // Stage 5: zero for a degenerate frame, else round to nearest, ties away from zero, then saturate.
    logic signed [W-1:0] world_next [3];
    logic signed [W-1:0] world_reg  [3];
    logic                deg_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            logic [AW-1:0]  amag;
            logic [AW-1:0]  rsum;
            logic [RQW-1:0] rq;
            logic [RQW-1:0] hi;
            amag = acc_reg[l][AW-1] ? AW'(-acc_reg[l]) : AW'(acc_reg[l]);
            rsum = amag + AW'(1 << (nfdt_pkg::FRAC_BITS - 1));
            rq   = rsum[AW-1:nfdt_pkg::FRAC_BITS];
            hi   = RQW'((64'd1 << (W - 1)) - 64'd1);
            if (deg4_reg)
            begin
                world_next[l] = '0;
            end
            else if (acc_reg[l][AW-1])
            begin
                world_next[l] = (rq > hi + RQW'(1)) ? $signed({1'b1, {(W-1){1'b0}}})
                                                   : $signed(W'(~rq + RQW'(1)));
            end
            else
            begin
                world_next[l] = (rq > hi) ? $signed(W'(hi)) : $signed(W'(rq));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            world_reg <= world_next;
            deg_reg   <= deg4_reg;
        end
    end

    // Valid bits of the local stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg    <= 1'b0;
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg    <= vec_in.valid;
            vld1_reg    <= n1_vld;
            vld2_reg    <= vld1_reg;
            vld3_reg    <= n2_vld;
            vld4_reg    <= vld3_reg;
            out_vld_reg <= vld4_reg;
        end
    end

    assign vec_out.valid      = out_vld_reg;
    assign vec_out.world_x    = world_reg[0];
    assign vec_out.world_y    = world_reg[1];
    assign vec_out.world_z    = world_reg[2];
    assign vec_out.degenerate = deg_reg;

    // A degenerate frame always yields a zero direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        vec_out.valid && vec_out.degenerate |->
            vec_out.world_x == '0 && vec_out.world_y == '0 && vec_out.world_z == '0)
        else $error("degenerate result with non-zero direction");

    // A held result freezes the whole pipeline, input side included.
    assert property (@(posedge clk) disable iff (!rst_n)
        vec_out.valid && !vec_out.ready |-> !vec_in.ready)
        else $error("input taken while a result is held");

    // A non-degenerate tangent component fits in one bit less than its signed width.
    assert property (@(posedge clk) disable iff (!rst_n)
        n1_vld && !n1_zero |->
            (u[0][UW-1] == u[0][UW-2]) && (u[1][UW-1] == u[1][UW-2])
            && (u[2][UW-1] == u[2][UW-2]))
        else $error("tangent component out of range");

endmodule
